FILE: design/assert_macros.svh
// Assertion macros shared by the averager RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("never failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: design/sdba_pkg.sv
// Package for the spectrum dB averager: constants, types, arithmetic helpers.
// No dependencies.
`default_nettype none
package sdba_pkg;
   localparam int MAX_BINS_DEF = 1024;
   localparam int CfgW = 17;
   localparam logic CSR_FFT_SIZE = 1'b0;
   localparam logic CSR_AVG_RESET = 1'b1;
   localparam logic signed [16:0] DB_FLOOR = -17'sd65536;
   localparam logic signed [16:0] AVG_RESET_DEF = -17'sd35840;
   localparam logic [3:0] FFT_LOG2_DEF = 4'd10;
   localparam logic signed [26:0] DB_CONST = 27'sd50504453;
   localparam logic signed [16:0] SMOOTH_GAIN = 17'sd32784;
   localparam logic signed [16:0] AVG_WEIGHT = 17'sd6554;

   // est + round_half_up(g*(s-est)/2^16)
   function automatic logic signed [16:0] blend(input logic signed [16:0] est,
         input logic signed [16:0] s, input logic signed [16:0] g);
      logic signed [18:0] d;
      logic signed [36:0] pr;
      logic signed [20:0] q;
      d = 19'(s) - 19'(est);
      pr = 37'(d) * 37'(g) + 37'sd32768;
      q = 21'(pr >>> 16);
      return 17'(21'(est) + q);
   endfunction
endpackage
`default_nettype wire

FILE: design/sdba_if.sv
// Valid/ready stream interfaces for the averager.
// Depends on nothing.
`default_nettype none
interface sdba_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] sample_re;
   logic signed [15:0] sample_im;
   modport source(output valid, sample_re, sample_im, input ready);
   modport sink(input valid, sample_re, sample_im, output ready);
endinterface

interface sdba_rsp_if;
   logic valid;
   logic ready;
   logic [9:0] bin_index;
   logic signed [16:0] smoothed_db;
   logic signed [16:0] averaged_db;
   logic signed [16:0] level_db;
   logic frame_last;
   modport source(output valid, bin_index, smoothed_db, averaged_db, level_db,
      frame_last, input ready);
   modport sink(input valid, bin_index, smoothed_db, averaged_db, level_db,
      frame_last, output ready);
endinterface
`default_nettype wire

FILE: design/sdba_log2.sv
// Pipelined log2 of bin power in Q.16 (integer part plus 16 squaring stages).
// Depends on sdba_pkg.
`default_nettype none
module sdba_log2 #(
   parameter int TagW = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [31:0]     in_power,
   input  wire logic [TagW-1:0] in_tag,
   output logic                 out_valid,
   output logic [21:0]          out_log,
   output logic                 out_zero,
   output logic [TagW-1:0]      out_tag
);
   import sdba_pkg::*;
   localparam int St = 17;
   logic [St:0] v_ff;
   logic [32:0] x_ff [St+1];
   logic [15:0] f_ff [St+1];
   logic [4:0]  e_ff [St+1];
   logic        z_ff [St+1];
   logic [TagW-1:0] t_ff [St+1];
   logic [4:0]  lead;
   logic [32:0] x0;

   always_comb begin
      lead = '0;
      for (int i = 0; i < 32; i++)
         if (in_power[i]) lead = 5'(i);
      x0 = 33'({in_power, 31'd0} >> lead);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[St-1:0], in_valid};
      if (en) begin
         x_ff[0] <= x0;
         f_ff[0] <= '0;
         e_ff[0] <= lead;
         z_ff[0] <= (in_power == '0);
         t_ff[0] <= in_tag;
         for (int k = 1; k <= 16; k++) begin
            logic [65:0] sq;
            sq = 66'(x_ff[k-1]) * 66'(x_ff[k-1]);
            sq = sq >> 31;
            if (sq[32]) begin
               x_ff[k] <= 33'(sq >> 1);
               f_ff[k] <= {f_ff[k-1][14:0], 1'b1};
            end else begin
               x_ff[k] <= sq[32:0];
               f_ff[k] <= {f_ff[k-1][14:0], 1'b0};
            end
            e_ff[k] <= e_ff[k-1];
            z_ff[k] <= z_ff[k-1];
            t_ff[k] <= t_ff[k-1];
         end
         x_ff[St] <= x_ff[16];
         f_ff[St] <= f_ff[16];
         e_ff[St] <= e_ff[16];
         z_ff[St] <= z_ff[16];
         t_ff[St] <= t_ff[16];
      end
   end

   assign out_valid = v_ff[St];
   assign out_log = {1'b0, e_ff[St], f_ff[St]};
   assign out_zero = z_ff[St];
   assign out_tag = t_ff[St];
endmodule
`default_nettype wire

FILE: design/spectrum_db_averager_top.sv
// Spectrum dB averager top: framing memory, log pipeline, smoothers, average RAM.
// Depends on sdba_pkg, sdba_if, sdba_log2, assert_macros.svh.
// One bin per clock is accepted while the output side takes results. Between the
// transfer of a bin and the rise of rsp.valid for its result lie the framing memory
// read, 18 log2 registers (normalize, 16 squaring stages, output), the dB multiply,
// the smoothers with the average memory read, and the output register. First-half
// bins wait in the framing memory and come out while the next frame's first half
// arrives. The whole pipeline advances only when its last stage is free, so rsp
// stalls hold req. Bins are seeded in shifted order from zero, so a high-water count
// stands in for the per-bin seeded flags.
`default_nettype none
module spectrum_db_averager_top #(
   parameter int MAX_BINS = sdba_pkg::MAX_BINS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_index,
   input  wire logic [sdba_pkg::CfgW-1:0] csr_wdata,
   sdba_req_if.sink req,
   sdba_rsp_if.source rsp
);
   import sdba_pkg::*;
   `include "assert_macros.svh"
   localparam int AW = $clog2(MAX_BINS);
   localparam int HW = AW - 1;
   localparam int MaxL = AW;
   localparam int TagW = AW + 6;

   logic [3:0] log2_ff;
   logic signed [16:0] avg_rst_ff;
   logic [AW:0] cnt_ff;
   logic primed_ff;
   logic [3:0] l_eff;
   logic [AW:0] n_sz, h_sz;
   logic en, acc;
   logic [31:0] hbuf [MAX_BINS/2];
   logic [31:0] rd_ff, word_ff;
   logic s0_v_ff, s0_low_ff;
   logic [AW-1:0] s0_pos_ff;
   logic [3:0] s0_l_ff;
   logic s0_last_ff;

   always_comb begin
      l_eff = (log2_ff < 4'd3) ? 4'd3 : log2_ff;
      if (32'(l_eff) > MaxL) l_eff = 4'(MaxL);
      n_sz = (AW+1)'(1) << l_eff;
      h_sz = n_sz >> 1;
   end

   assign en = !rsp.valid || rsp.ready;
   assign req.ready = en && !reset;
   assign acc = req.valid && req.ready;

   logic [AW:0] c;
   logic low;
   always_comb begin
      c = (cnt_ff >= n_sz) ? '0 : cnt_ff;
      low = c < h_sz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= FFT_LOG2_DEF;
         avg_rst_ff <= AVG_RESET_DEF;
         cnt_ff <= '0;
         primed_ff <= 1'b0;
         s0_v_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_FFT_SIZE) begin
            log2_ff <= csr_wdata[3:0];
            cnt_ff <= '0;
            primed_ff <= 1'b0;
         end else if (csr_we && csr_index == CSR_AVG_RESET) begin
            avg_rst_ff <= csr_wdata;
         end
         if (en) s0_v_ff <= acc && (!low || primed_ff);
         if (acc) begin
            if (c + 1'b1 >= n_sz) begin
               cnt_ff <= '0;
               primed_ff <= 1'b1;
            end else cnt_ff <= c + 1'b1;
         end
      end
   end

   logic [HW-1:0] ha;
   assign ha = c[HW-1:0];
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= hbuf[ha];
         word_ff <= {req.sample_im, req.sample_re};
         s0_low_ff <= low;
         s0_pos_ff <= low ? AW'(h_sz + c) : AW'(c - h_sz);
         s0_last_ff <= low && (c + 1'b1 == h_sz);
         s0_l_ff <= l_eff;
      end
      if (acc && low) hbuf[ha] <= {req.sample_im, req.sample_re};
   end

   logic [31:0] use_w;
   logic signed [15:0] ure, uim;
   logic signed [31:0] pre, pim;
   logic [31:0] pw;
   assign use_w = s0_low_ff ? rd_ff : word_ff;
   assign ure = use_w[15:0];
   assign uim = use_w[31:16];
   assign pre = ure * ure;
   assign pim = uim * uim;
   assign pw = pre + pim;

   logic lg_v, lg_z;
   logic [21:0] lg;
   logic [TagW-1:0] lg_t;
   sdba_log2 #(.TagW(TagW)) u_log2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(s0_v_ff), .in_power(pw),
      .in_tag({s0_last_ff, s0_l_ff, (s0_pos_ff == '0), s0_pos_ff}),
      .out_valid(lg_v), .out_log(lg), .out_zero(lg_z), .out_tag(lg_t));

   // dB multiply stage
   logic d1_v_ff;
   logic [TagW-1:0] d1_t_ff;
   logic signed [49:0] ds_ff, dl_ff;
   logic d1_z_ff;
   logic signed [23:0] dsig, dlev;
   logic [3:0] tl;
   assign tl = lg_t[AW+4:AW+1];
   assign dsig = 24'sd2 * (24'(signed'({1'b0, lg})) - 24'(signed'({1'b0, tl, 17'd0})));
   assign dlev = 24'(signed'({1'b0, lg})) - 24'(signed'({1'b0, tl, 16'd0}));
   always_ff @(posedge clock) begin
      if (reset) d1_v_ff <= 1'b0;
      else if (en) d1_v_ff <= lg_v;
      if (en) begin
         d1_t_ff <= lg_t;
         d1_z_ff <= lg_z;
         ds_ff <= 50'(dsig) * 50'(DB_CONST);
         dl_ff <= 50'(dlev) * 50'(DB_CONST);
      end
   end
   logic signed [16:0] sig, lev;
   logic signed [49:0] sr, lr;
   always_comb begin
      sr = (ds_ff + 50'sh80000000) >>> 32;
      lr = (dl_ff + 50'sh80000000) >>> 32;
      sig = d1_z_ff ? DB_FLOOR : 17'(sr);
      lev = d1_z_ff ? DB_FLOOR : 17'(lr);
   end

   // smoothers
   logic signed [16:0] se_ff, le_ff, se_in, le_in;
   logic sm_v_ff;
   logic [TagW-1:0] sm_t_ff;
   always_comb begin
      se_in = blend(d1_t_ff[AW] ? 17'sd0 : se_ff, sig, SMOOTH_GAIN);
      le_in = blend(d1_t_ff[AW] ? 17'sd0 : le_ff, lev, SMOOTH_GAIN);
   end
   logic [AW:0] fill_ff;
   logic signed [16:0] avg_mem [MAX_BINS];
   logic signed [16:0] am_rd_ff;
   logic am_seed_ff;
   logic [AW-1:0] dpos;
   assign dpos = d1_t_ff[AW-1:0];
   always_ff @(posedge clock) begin
      if (reset) begin
         se_ff <= '0;
         le_ff <= '0;
         sm_v_ff <= 1'b0;
      end else if (en) begin
         sm_v_ff <= d1_v_ff;
         if (d1_v_ff) begin
            se_ff <= se_in;
            le_ff <= le_in;
         end
      end
      if (en) begin
         sm_t_ff <= d1_t_ff;
         am_rd_ff <= avg_mem[dpos];
         am_seed_ff <= ({1'b0, dpos} < fill_ff);
      end
   end

   // average update; a position recurs only N >= 8 transfers later
   logic signed [16:0] a_old, a_new;
   logic [AW-1:0] spos;
   assign spos = sm_t_ff[AW-1:0];
   assign a_old = am_seed_ff ? am_rd_ff : avg_rst_ff;
   assign a_new = blend(a_old, se_ff, AVG_WEIGHT);
   logic o_v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= sm_v_ff;
         if (sm_v_ff && {1'b0, spos} == fill_ff) fill_ff <= fill_ff + 1'b1;
      end
      if (en && sm_v_ff) avg_mem[spos] <= a_new;
      if (en) begin
         rsp.bin_index <= 10'(spos);
         rsp.smoothed_db <= se_ff;
         rsp.level_db <= le_ff;
         rsp.averaged_db <= a_new;
         rsp.frame_last <= sm_t_ff[AW+5];
      end
   end
   assign rsp.valid = o_v_ff;

   `ASSERT_CLK(a_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid)
   `ASSERT_NEVER(a_acc_stall, clock, reset, acc && rsp.valid && !rsp.ready)
   `ASSERT_CLK(a_first, clock, reset, o_v_ff && rsp.bin_index == 10'd0 |-> !rsp.frame_last)
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for spectrum_db_averager_top: random and directed FFT bins,
// fft-shifted dB results predicted in-line and compared per transfer.
// Depends on sdba_pkg, sdba_if and the averager RTL.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sdba_pkg::*;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } fft_bin_type;

   typedef struct {
      logic [9:0] bin_index;
      logic signed [16:0] smoothed_db;
      logic signed [16:0] averaged_db;
      logic signed [16:0] level_db;
      logic frame_last;
   } db_result_type;

   bit clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = CSR_FFT_SIZE;
   logic [CfgW-1:0] csr_wdata = '0;

   sdba_req_if req_ch();
   sdba_rsp_if rsp_ch();

   spectrum_db_averager_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   fft_bin_type pending_bins[$];
   db_result_type expected_bins[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   longint cycles = 0;

   // shadow state of the averager
   logic [31:0] half_buf[512];
   logic signed [16:0] avg_mem[1024];
   bit seeded[1024];
   longint sm_est, lv_est;
   int unsigned bin_cnt;
   bit primed;
   logic [3:0] size_reg;
   logic signed [16:0] avg_reset_lvl;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint round_shift(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint log2_fix(longint unsigned p);
      int e;
      longint unsigned x, frac;
      e = 0;
      frac = 0;
      while (e < 63 && (p >> (e + 1)) != 0) e++;
      x = (e <= 31) ? (p << (31 - e)) : (p >> (e - 31));
      for (int k = 0; k < 16; k++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= 64'h1_0000_0000) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      return (longint'(e) << 16) | longint'(frac);
   endfunction

   task automatic predict_bin(input logic signed [15:0] re_in, input logic signed [15:0] im_in);
      int unsigned l, n, h, c, pos;
      logic [31:0] word, used;
      bit have;
      longint re, im, lg, sig, lev, avg;
      longint unsigned p;
      db_result_type r;
      l = size_reg < 3 ? 3 : (size_reg > 10 ? 10 : size_reg);
      n = 1 << l;
      h = n >> 1;
      c = bin_cnt;
      word = {im_in, re_in};
      have = 1'b1;
      if (c >= n) c = 0;
      if (c < h) begin
         have = primed;
         used = half_buf[c];
         half_buf[c] = word;
         pos = h + c;
      end else begin
         used = word;
         pos = c - h;
      end
      c++;
      if (c >= n) begin
         c = 0;
         primed = 1'b1;
      end
      bin_cnt = c;
      if (!have) return;
      re = longint'($signed(used[15:0]));
      im = longint'($signed(used[31:16]));
      p = longint'(re * re + im * im);
      if (p == 0) begin
         sig = DB_FLOOR;
         lev = DB_FLOOR;
      end else begin
         lg = log2_fix(p);
         sig = round_shift(2 * (lg - (longint'(2 * l) << 16)) * longint'(DB_CONST), 32);
         lev = round_shift((lg - (longint'(l) << 16)) * longint'(DB_CONST), 32);
      end
      if (pos == 0) begin
         sm_est = 0;
         lv_est = 0;
      end
      sm_est = sm_est + round_shift(longint'(SMOOTH_GAIN) * (sig - sm_est), 16);
      lv_est = lv_est + round_shift(longint'(SMOOTH_GAIN) * (lev - lv_est), 16);
      avg = seeded[pos] ? longint'(avg_mem[pos]) : longint'(avg_reset_lvl);
      avg = avg + round_shift(longint'(AVG_WEIGHT) * (sm_est - avg), 16);
      avg_mem[pos] = avg[16:0];
      seeded[pos] = 1'b1;
      r.bin_index = pos[9:0];
      r.smoothed_db = sm_est[16:0];
      r.averaged_db = avg[16:0];
      r.level_db = lv_est[16:0];
      r.frame_last = (pos == n - 1);
      expected_bins.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.sample_re <= '0;
         req_ch.sample_im <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_bin(req_ch.sample_re, req_ch.sample_im);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_bins.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               fft_bin_type b;
               b = pending_bins.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.sample_re <= b.re;
               req_ch.sample_im <= b.im;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bins.size() == 0) begin
               report_mismatch("unexpected transfer, bin_index", rsp_ch.bin_index, -1);
            end else begin
               db_result_type w;
               w = expected_bins.pop_front();
               if (rsp_ch.bin_index !== w.bin_index)
                  report_mismatch("bin_index", rsp_ch.bin_index, w.bin_index);
               if (rsp_ch.smoothed_db !== w.smoothed_db)
                  report_mismatch("smoothed_db", rsp_ch.smoothed_db, w.smoothed_db);
               if (rsp_ch.averaged_db !== w.averaged_db)
                  report_mismatch("averaged_db", rsp_ch.averaged_db, w.averaged_db);
               if (rsp_ch.level_db !== w.level_db)
                  report_mismatch("level_db", rsp_ch.level_db, w.level_db);
               if (rsp_ch.frame_last !== w.frame_last)
                  report_mismatch("frame_last", rsp_ch.frame_last, w.frame_last);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_bins.size() > 0 || req_ch.valid || expected_bins.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CfgW-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_FFT_SIZE) begin
         size_reg = data[3:0];
         bin_cnt = 0;
         primed = 1'b0;
      end else begin
         avg_reset_lvl = data;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic fft_bin_type random_bin();
      fft_bin_type b;
      case ($urandom_range(4))
         0: begin
            b.re = '0;
            b.im = '0;
         end
         1: begin
            b.re = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
            b.im = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
         end
         2: begin
            b.re = $signed(16'($urandom_range(15))) - 16'sd8;
            b.im = $signed(16'($urandom_range(15))) - 16'sd8;
         end
         default: begin
            b.re = 16'($urandom);
            b.im = 16'($urandom);
         end
      endcase
      return b;
   endfunction

   function automatic fft_bin_type mk(input int re, input int im);
      fft_bin_type b;
      b.re = 16'(re);
      b.im = 16'(im);
      return b;
   endfunction

   initial begin
      int sizes[8] = '{3, 4, 0, 5, 6, 4, 3, 5};
      logic signed [16:0] lvl;
      size_reg = FFT_LOG2_DEF;
      avg_reset_lvl = AVG_RESET_DEF;
      bin_cnt = 0;
      primed = 1'b0;
      sm_est = 0;
      lv_est = 0;
      foreach (seeded[i]) seeded[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_FFT_SIZE, 17'd3);
      write_csr(CSR_AVG_RESET, 17'd0);
      pending_bins = '{mk(-32768, -32768), mk(32767, 32767), mk(0, 0), mk(1, 0),
         mk(-1, -1), mk(0, -32768), mk(32767, 0), mk(0, 1),
         mk(-32768, 32767), mk(0, 0), mk(12345, -4321), mk(-1, 0),
         mk(32767, -32768), mk(2, 2), mk(0, 0), mk(-32768, 0),
         mk(1, 1), mk(-32768, -32768), mk(32767, 32767), mk(0, 0),
         mk(0, 0), mk(100, -100), mk(-7, 3), mk(0, 32767)};
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 80; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 80; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         write_csr(CSR_FFT_SIZE, 17'(sizes[ph]));
         lvl = (ph == 1) ? -17'sd65536 : (ph == 5) ? 17'sd0
            : -$signed(17'($urandom_range(65536)));
         write_csr(CSR_AVG_RESET, lvl);
         for (int i = 0; i < 40; i++) begin
            pending_bins.push_back(random_bin());
            if (ph == 2 && i == 20) begin
               while (pending_bins.size() > 0 || req_ch.valid || expected_bins.size() > 0)
                  @(posedge clock);
            end
         end
         wait_drained();
      end

      // largest size, selected through an over-range value
      send_idle_pct = 0;
      stall_pct = 0;
      write_csr(CSR_FFT_SIZE, 17'd15);
      write_csr(CSR_AVG_RESET, -17'sd35840);
      for (int i = 0; i < 206; i++) pending_bins.push_back(random_bin());
      wait_drained();

      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
